>>> sv/sft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sft_pkg
// Shared types, constants and helpers of the symbol frequency table.
// ----------------------------------------------------------------------------
package sft_pkg;

	localparam int ENTRIES   = 32;
	localparam int CNT_W     = 24;
	localparam int SYM_W     = 16;
	localparam int TGT_W     = 16;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int IDX_OUT_W = 5;
	localparam int PROD_W    = CNT_W + TGT_W;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SYM_W-1:0]  sym_t;
	typedef logic [TGT_W-1:0]  tgt_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [PROD_W-1:0] prod_t;

	localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		KIND_COUNT = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
		sym_t  symbol;
		cnt_t  total;
		prod_t pd;
		prod_t best;
		logic  done;
		logic  was_new;
		logic  empty;
		idx_t  idx;
		cnt_t  cnt;
	} sft_tok_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == CNT_MAX) ? v : cnt_t'(v + 1'b1);
	endfunction

endpackage
`default_nettype wire

>>> sv/symbol_frequency_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// symbol_frequency_table
// Associative frequency table of 16-bit symbols with nearest-frequency query.
// ----------------------------------------------------------------------------
// Every beat on the input (count, query or clear; kind 3 is taken and dropped)
// becomes a token that walks a row of ENTRIES cells, one cell per cycle unless
// the output stalls, each cell holding one table slot. Tokens follow one
// another, so the block sustains one beat per cycle while unstalled; a result
// passes the entry stage (target-times-(total - 1) multiply), the cell row and
// the output register. A stalled output holds the whole row.
// ----------------------------------------------------------------------------
module symbol_frequency_table
	import sft_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // symbol[15:0], target[31:16]
	input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// found_symbol[15:0], entry_index[20:16], entry_count[44:21],
	// total_seen[68:45], zero[71:69]
	output logic [71:0]      m_axis_tdata,
	output logic [2:0]       m_axis_tuser   // was_new, table_full, table_empty
);

	logic              adv;
	sft_tok_t          chain [0:ENTRIES];
	logic [31:0]       idx_wide;
	logic [71:0]       data_d;
	logic [2:0]        user_d;
	sft_tok_t          last;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	sft_head u_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_axis_tvalid && s_axis_tready),
		.kind     (s_axis_tuser),
		.symbol   (s_axis_tdata[15:0]),
		.target   (s_axis_tdata[31:16]),
		.tok_s1   (chain[0])
	);

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		sft_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.idx     (idx_t'(i)),
			.tok_in  (chain[i]),
			.tok_q   (chain[i+1])
		);
	end

	assign last     = chain[ENTRIES];
	assign idx_wide = 32'(last.idx);

	always_comb begin
		data_d = '0;
		user_d = '0;
		case (last.kind)
			KIND_COUNT: begin
				data_d[68:45] = last.total;
				if (last.done) begin
					data_d[15:0]  = last.symbol;
					data_d[20:16] = idx_wide[IDX_OUT_W-1:0];
					data_d[44:21] = last.cnt;
					user_d[0]     = last.was_new;
				end else begin
					user_d[1] = 1'b1;
				end
			end
			KIND_QUERY: begin
				data_d[68:45] = last.total;
				if (last.empty) begin
					user_d[2] = 1'b1;
				end else begin
					data_d[15:0]  = last.symbol;
					data_d[20:16] = idx_wide[IDX_OUT_W-1:0];
					data_d[44:21] = last.cnt;
				end
			end
			KIND_CLEAR: begin
				user_d[2] = 1'b1;
			end
			default: begin
				user_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= data_d;
			m_axis_tuser <= user_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled output beat changed");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata == '0))
		else $error("empty-table result carries nonzero data");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0(m_axis_tuser))
		else $error("more than one status flag set");
`endif

endmodule
`default_nettype wire

>>> sv/sft_head.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sft_head
// Entry stage: keeps the running total and builds the token for the chain.
// ----------------------------------------------------------------------------
module sft_head
	import sft_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire logic     in_valid,
	input  wire logic [1:0] kind,
	input  wire sym_t     symbol,
	input  wire tgt_t     target,
	output sft_tok_t      tok_s1
);

	cnt_t     total_q;
	cnt_t     total_d;
	cnt_t     dist_d;
	prod_t    pd;
	sft_tok_t tok_d;

	always_comb begin
		dist_d  = cnt_t'(total_q - 1'b1);
		pd      = prod_t'(target) * prod_t'(dist_d);
		total_d = total_q;
		tok_d   = '0;
		tok_d.symbol = symbol;
		if (in_valid) begin
			case (kind)
				KIND_COUNT: begin
					total_d     = sat_inc(total_q);
					tok_d.valid = 1'b1;
					tok_d.kind  = KIND_COUNT;
					tok_d.total = total_d;
				end
				KIND_QUERY: begin
					tok_d.valid = 1'b1;
					tok_d.kind  = KIND_QUERY;
					tok_d.total = total_q;
					if (total_q > cnt_t'(1)) begin
						tok_d.pd   = pd;
						tok_d.best = {dist_d, {TGT_W{1'b0}}};
					end
				end
				KIND_CLEAR: begin
					total_d     = '0;
					tok_d.valid = 1'b1;
					tok_d.kind  = KIND_CLEAR;
				end
				default: begin
					tok_d.valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			tok_s1  <= '0;
		end else if (adv) begin
			total_q <= total_d;
			tok_s1  <= tok_d;
		end
	end

endmodule
`default_nettype wire

>>> sv/sft_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sft_cell
// One table slot: holds a symbol and its count, updates or reads the slot
// for the token passing by and hands the token to the next cell.
// ----------------------------------------------------------------------------
module sft_cell
	import sft_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire idx_t     idx,
	input  wire sft_tok_t tok_in,
	output sft_tok_t      tok_q
);

	logic     valid_q;
	sym_t     sym_q;
	cnt_t     cnt_q;
	sft_tok_t tok_d;
	logic     valid_d;
	logic     sym_we;
	logic     cnt_we;
	cnt_t     cnt_d;
	prod_t    scaled;
	prod_t    diff;
	cnt_t     cnt_inc;

	always_comb begin
		scaled  = {cnt_q, {TGT_W{1'b0}}};
		diff    = (scaled >= tok_in.pd) ? prod_t'(scaled - tok_in.pd)
		                                : prod_t'(tok_in.pd - scaled);
		cnt_inc = sat_inc(cnt_q);
		tok_d   = tok_in;
		valid_d = valid_q;
		sym_we  = 1'b0;
		cnt_we  = 1'b0;
		cnt_d   = cnt_inc;
		if (tok_in.valid) begin
			case (tok_in.kind)
				KIND_COUNT: begin
					if (!tok_in.done) begin
						if (valid_q && (sym_q == tok_in.symbol)) begin
							cnt_we      = 1'b1;
							tok_d.done  = 1'b1;
							tok_d.idx   = idx;
							tok_d.cnt   = cnt_inc;
						end else if (!valid_q) begin
							sym_we        = 1'b1;
							cnt_we        = 1'b1;
							cnt_d         = cnt_t'(1);
							valid_d       = 1'b1;
							tok_d.done    = 1'b1;
							tok_d.was_new = 1'b1;
							tok_d.idx     = idx;
							tok_d.cnt     = cnt_t'(1);
						end
					end
				end
				KIND_QUERY: begin
					if (idx == '0) begin
						tok_d.empty  = !valid_q;
						tok_d.idx    = '0;
						tok_d.symbol = valid_q ? sym_q : '0;
						tok_d.cnt    = valid_q ? cnt_q : '0;
					end
					if (valid_q && (diff < tok_in.best)) begin
						tok_d.best   = diff;
						tok_d.idx    = idx;
						tok_d.symbol = sym_q;
						tok_d.cnt    = cnt_q;
					end
				end
				KIND_CLEAR: begin
					valid_d = 1'b0;
				end
				default: begin
					tok_d = tok_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else if (adv) begin
			valid_q <= valid_d;
			tok_q   <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && sym_we) begin
			sym_q <= tok_in.symbol;
		end
		if (adv && cnt_we) begin
			cnt_q <= cnt_d;
		end
	end

endmodule
`default_nettype wire

>>> bench/symbol_frequency_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_frequency_table_tb
// Self-checking bench for the symbol frequency table. Beats are sent on the
// input stream with random gaps, and the output is stalled at random. A
// behavioral copy of the table (slots, counts, total) predicts every result,
// and each output beat is compared field by field with the oldest prediction.
// Directed tests cover the empty table, a single entry, nearest-frequency
// ties and misses, and a full table that drops symbols. Random segments then
// mix counts over alphabets of varied size with queries, clears and ignored
// beats.
// ----------------------------------------------------------------------------
module symbol_frequency_table_tb;
	import sft_pkg::*;

	localparam logic [1:0] KIND_IGNORED = 2'd3;
	localparam int         LATENCY      = ENTRIES + 2;
	localparam int         DRAIN_CYCLES = 2 * LATENCY + 10;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         MAX_GAP      = 17;
	localparam int         MAX_REPORTS  = 50;

	typedef struct packed {
		sym_t                 found;
		logic [IDX_OUT_W-1:0] idx;
		cnt_t                 cnt;
		cnt_t                 total;
		logic                 was_new;
		logic                 full;
		logic                 empty;
	} table_result_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	// table image
	sym_t        tbl_sym [ENTRIES];
	cnt_t        tbl_cnt [ENTRIES];
	int unsigned tbl_used;
	cnt_t        tbl_total;

	table_result_t pending_results[$];

	bit          tx_calm;
	bit          rx_calm;
	int unsigned mismatches;
	int unsigned n_counts, n_queries, n_clears, n_ignored, n_new, n_dropped;
	int unsigned n_checked;

	symbol_frequency_table uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		if (mismatches < MAX_REPORTS)
			$display("ERROR @%0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
		mismatches++;
	endtask

	// advance the table image by one beat and queue its result, if it has one
	task automatic predict_table_step(input logic [1:0] kind, input sym_t sym,
			input tgt_t tgt);
		table_result_t r;
		int unsigned   slot;
		int unsigned   sel;
		bit            hit;
		logic [47:0]   span;
		logic [47:0]   scaled;
		logic [47:0]   best;
		logic [47:0]   lhs;
		logic [47:0]   diff;
		r    = '0;
		hit  = 1'b0;
		slot = 0;
		sel  = 0;
		case (kind)
			KIND_COUNT: begin
				n_counts++;
				for (int i = 0; i < tbl_used; i++)
					if (!hit && tbl_sym[i] == sym) begin
						hit  = 1'b1;
						slot = i;
					end
				if (tbl_total != CNT_MAX)
					tbl_total = tbl_total + 1'b1;
				if (hit) begin
					if (tbl_cnt[slot] != CNT_MAX)
						tbl_cnt[slot] = tbl_cnt[slot] + 1'b1;
					r.found = sym;
					r.idx   = slot[IDX_OUT_W-1:0];
					r.cnt   = tbl_cnt[slot];
				end else if (tbl_used < ENTRIES) begin
					tbl_sym[tbl_used] = sym;
					tbl_cnt[tbl_used] = cnt_t'(1);
					r.found   = sym;
					r.idx     = tbl_used[IDX_OUT_W-1:0];
					r.cnt     = cnt_t'(1);
					r.was_new = 1'b1;
					tbl_used++;
					n_new++;
				end else begin
					r.full = 1'b1;
					n_dropped++;
				end
				r.total = tbl_total;
			end
			KIND_QUERY: begin
				n_queries++;
				if (tbl_used == 0) begin
					r.empty = 1'b1;
				end else begin
					if (tbl_total > 1) begin
						span   = 48'(tbl_total) - 1;
						scaled = 48'(tgt) * span;
						best   = span << 16;
						for (int i = 0; i < tbl_used; i++) begin
							lhs  = 48'(tbl_cnt[i]) << 16;
							diff = (lhs >= scaled) ? lhs - scaled : scaled - lhs;
							if (diff < best) begin
								best = diff;
								sel  = i;
							end
						end
					end
					r.found = tbl_sym[sel];
					r.idx   = sel[IDX_OUT_W-1:0];
					r.cnt   = tbl_cnt[sel];
					r.total = tbl_total;
				end
			end
			KIND_CLEAR: begin
				n_clears++;
				tbl_used  = 0;
				tbl_total = '0;
				r.empty   = 1'b1;
			end
			default: begin
				n_ignored++;
				return;
			end
		endcase
		pending_results.push_back(r);
	endtask

	// present one beat and hold it until taken
	task automatic send_beat(input logic [1:0] kind, input sym_t sym, input tgt_t tgt);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {tgt, sym};
		predict_table_step(kind, sym, tgt);
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_count(input sym_t sym);
		send_beat(KIND_COUNT, sym, tgt_t'($urandom));
	endtask

	task automatic send_query(input tgt_t tgt);
		send_beat(KIND_QUERY, sym_t'($urandom), tgt);
	endtask

	task automatic send_clear();
		send_beat(KIND_CLEAR, sym_t'($urandom), tgt_t'($urandom));
	endtask

	task automatic test_empty_table();
		send_query(16'h0000);
		send_query(16'hFFFF);
		send_clear();
		send_beat(KIND_IGNORED, 16'hFFFF, 16'hFFFF);
		send_query(16'h8000);
	endtask

	task automatic test_single_entry();
		send_count(16'hFFFF);
		send_query(16'h8000);
		send_count(16'hFFFF);
		send_count(16'hFFFF);
		// for target 0 no entry beats the bound of 1.0
		send_query(16'h0000);
		send_query(16'hFFFF);
	endtask

	task automatic test_nearest_frequency();
		send_clear();
		send_count(16'h0000);
		send_count(16'h1234);
		send_count(16'h1234);
		send_count(16'hC0DE);
		send_count(16'hC0DE);
		send_count(16'hFFFF);
		// tie between two slots: the first one wins
		send_query(16'h6666);
		send_query(16'h3333);
		send_query(16'hFFFF);
		send_query(16'h0000);
	endtask

	task automatic test_full_table();
		sym_t base;
		base = sym_t'($urandom);
		send_clear();
		for (int i = 0; i < ENTRIES; i++)
			send_count(base ^ sym_t'(i * 16'h0801));
		for (int i = ENTRIES; i < ENTRIES + 3; i++)
			send_count(base ^ sym_t'(i * 16'h0801));
		send_count(base ^ sym_t'((ENTRIES - 1) * 16'h0801));
		send_query(tgt_t'($urandom));
		send_clear();
	endtask

	task automatic test_random_traffic(input int unsigned goal);
		int unsigned sent;
		int unsigned alpha_size;
		int unsigned seg_len;
		int unsigned roll;
		int unsigned pick;
		int unsigned sizes[9];
		sym_t        alphabet[$];
		logic [47:0] ratio;
		sizes = '{1, 3, 8, 16, 31, 32, 33, 48, 64};
		sent  = 0;
		while (sent < goal) begin
			alpha_size = sizes[$urandom_range(0, 8)];
			seg_len    = $urandom_range(20, 90);
			tx_calm    = ($urandom_range(0, 3) == 0);
			rx_calm    = ($urandom_range(0, 3) == 0);
			alphabet.delete();
			for (int i = 0; i < alpha_size; i++)
				alphabet.push_back(sym_t'($urandom));
			if ($urandom_range(0, 1) == 1) begin
				send_clear();
				sent++;
			end
			for (int j = 0; j < seg_len; j++) begin
				roll = $urandom_range(0, 99);
				if (roll < 68) begin
					// skew toward the head of the alphabet
					pick = $urandom_range(0, $urandom_range(0, alpha_size - 1));
					send_count(alphabet[pick]);
					sent++;
				end else if (roll < 73) begin
					send_count(sym_t'($urandom));
					sent++;
				end else if (roll < 93) begin
					if (roll < 83 && tbl_used > 0 && tbl_total > 1) begin
						pick  = $urandom_range(0, tbl_used - 1);
						ratio = (48'(tbl_cnt[pick]) << 16) / (48'(tbl_total) - 1);
						if (ratio > 48'hFFFF)
							ratio = 48'hFFFF;
						send_query(tgt_t'(ratio));
					end else begin
						send_query(tgt_t'($urandom));
					end
					sent++;
				end else if (roll < 97) begin
					send_beat(KIND_IGNORED, sym_t'($urandom), tgt_t'($urandom));
				end else begin
					send_clear();
					sent++;
				end
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// output stall pattern
	initial begin : result_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	initial begin : result_checker
		table_result_t got;
		table_result_t want;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.found   = m_axis_tdata[15:0];
				got.idx     = m_axis_tdata[20:16];
				got.cnt     = m_axis_tdata[44:21];
				got.total   = m_axis_tdata[68:45];
				got.was_new = m_axis_tuser[0];
				got.full    = m_axis_tuser[1];
				got.empty   = m_axis_tuser[2];
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected beat, found_symbol", 0, got.found);
				end else begin
					want = pending_results.pop_front();
					n_checked++;
					if (got.found !== want.found)
						report_mismatch("found_symbol", want.found, got.found);
					if (got.idx !== want.idx)
						report_mismatch("entry_index", want.idx, got.idx);
					if (got.cnt !== want.cnt)
						report_mismatch("entry_count", want.cnt, got.cnt);
					if (got.total !== want.total)
						report_mismatch("total_seen", want.total, got.total);
					if (got.was_new !== want.was_new)
						report_mismatch("was_new", want.was_new, got.was_new);
					if (got.full !== want.full)
						report_mismatch("table_full", want.full, got.full);
					if (got.empty !== want.empty)
						report_mismatch("table_empty", want.empty, got.empty);
					if (m_axis_tdata[71:69] !== 3'b000)
						report_mismatch("tdata pad", 0, m_axis_tdata[71:69]);
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("ERROR: no beat moved for %0d cycles, %0d results pending",
			IDLE_LIMIT, pending_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : sequencer
		tbl_used  = 0;
		tbl_total = '0;
		tx_calm   = 1'b0;
		rx_calm   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_single_entry();
		test_nearest_frequency();
		test_full_table();
		test_random_traffic(1000);

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d counts (%0d new, %0d dropped), %0d queries, %0d clears,",
			n_counts, n_new, n_dropped, n_queries, n_clears);
		$display("%0d ignored beats; %0d results checked, %0d mismatches.",
			n_ignored, n_checked, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
